// ===== rtl/bmfa_pkg.sv =====
`default_nettype none

package bmfa_pkg;

    // Field and register widths
    localparam int CNT_W    = 14;
    localparam int NUM_W    = 14;
    localparam int STATUS_W = 2;

    // Parameter defaults
    localparam int MAP_BITS_DEFAULT  = 8192;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 14'd8192;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;

    localparam logic MAP_INODE = 1'b0;
    localparam logic MAP_BLOCK = 1'b1;

    localparam logic REG_INODE_COUNT = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/bmfa_word_scan.sv =====
`default_nettype none

module bmfa_word_scan #(
    parameter int WORD_BITS = bmfa_pkg::WORD_BITS_DEFAULT,
    parameter int USE_W     = $clog2(WORD_BITS + 1),
    parameter int BIT_W     = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [USE_W-1:0]     usable,
    output logic                      hit,
    output logic [BIT_W-1:0]          hit_bit
);

    // Lowest clear bit among the low 'usable' bits of the word
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i] && (USE_W'(i) < usable))
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_first_fit_allocator.sv =====
`default_nettype none

// First-fit allocator over two bitmaps (inode map and block map) held in one
// synchronous RAM, one word of WORD_BITS bits per entry.
// Command channel: an item is taken at a clock edge with start high and busy
// low. The result (allocated_number, status) is shown for one cycle with done
// high; the receiver cannot hold it off, so there is no stall path.
// Configuration: write_enable, write_index, write_data; index 0 is the inode
// count, index 1 the block count. Write only while busy is low.
// Steps from the transfer edge to done:
//   free, in range         : read the word, write it back
//   free out of range      : done set straight from idle, status RANGE
//   allocate               : scan the words in order, one RAM word per
//                            cycle, until a clear bit is found or the
//                            end of the count is reached
//   allocate, count zero   : done set straight from idle, status FULL
// One item is in flight at a time; busy is low again when done is shown.
// After reset a clearing pass zeroes both maps, one RAM word a cycle;
// busy is high for its length and configuration writes are still taken.
module bitmap_first_fit_allocator #(
    parameter int MAP_BITS  = bmfa_pkg::MAP_BITS_DEFAULT,
    parameter int WORD_BITS = bmfa_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic                          map_select,
    input  wire logic [bmfa_pkg::CNT_W-1:0]    entry_number,
    output logic                               done,
    output logic [bmfa_pkg::NUM_W-1:0]         allocated_number,
    output logic [bmfa_pkg::STATUS_W-1:0]      status,
    input  wire logic                          write_enable,
    input  wire logic                          write_index,
    input  wire logic [bmfa_pkg::CNT_W-1:0]    write_data
);

    import bmfa_pkg::*;

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int ADDR_W    = WADDR_W + 1;
    localparam int MEM_DEPTH = 2 << WADDR_W;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int USE_W     = $clog2(WORD_BITS + 1);
    localparam int MAPB_W    = $clog2(MAP_BITS + 1);
    localparam int LIM_W     = (MAPB_W > CNT_W) ? MAPB_W : CNT_W;
    localparam int BASE_W    = LIM_W + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_SCAN
    } state_t;

    // Configuration registers
    logic [CNT_W-1:0] inode_count_reg;
    logic [CNT_W-1:0] block_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inode_count_reg <= COUNT_RESET;
            block_count_reg <= COUNT_RESET;
        end
        else if (write_enable)
        begin
            if (write_index == REG_INODE_COUNT)
                inode_count_reg <= write_data;
            else
                block_count_reg <= write_data;
        end
    end

    // Bitmap RAM, addressed by {map, word}
    logic [WORD_BITS-1:0] mem [0:MEM_DEPTH-1];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                sel_reg, sel_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic [WADDR_W-1:0]  word_reg, word_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [NUM_W-1:0]    number_reg, number_next;
    status_t             status_reg, status_next;

    // Request decode
    logic [CNT_W-1:0]    count_in;
    logic [LIM_W-1:0]    limit_in;
    logic [LIM_W-1:0]    num_in;
    logic [LIM_W-1:0]    free_idx;
    logic                free_bad;
    logic [WADDR_W-1:0]  free_word;

    assign count_in  = (map_select == MAP_BLOCK) ? block_count_reg : inode_count_reg;
    assign limit_in  = (LIM_W'(count_in) > LIM_W'(MAP_BITS)) ? LIM_W'(MAP_BITS)
                                                             : LIM_W'(count_in);
    assign num_in    = LIM_W'(entry_number);
    assign free_bad  = (num_in == '0) || (num_in > limit_in);
    assign free_idx  = num_in - LIM_W'(1);
    assign free_word = WADDR_W'(free_idx >> BIT_W);

    // Scan of the current word
    logic [BASE_W-1:0]  rem;
    logic [USE_W-1:0]   usable;
    logic               hit;
    logic [BIT_W-1:0]   hit_bit;
    logic [BASE_W-1:0]  base_step;
    logic [BASE_W-1:0]  found_num;

    assign rem       = BASE_W'(limit_reg) - base_reg;
    assign usable    = (rem >= BASE_W'(WORD_BITS)) ? USE_W'(WORD_BITS) : rem[USE_W-1:0];
    assign base_step = base_reg + BASE_W'(WORD_BITS);
    assign found_num = base_reg + BASE_W'(hit_bit) + BASE_W'(1);

    bmfa_word_scan #(
        .WORD_BITS (WORD_BITS),
        .USE_W     (USE_W),
        .BIT_W     (BIT_W)
    ) u_scan (
        .word    (rd_data_reg),
        .usable  (usable),
        .hit     (hit),
        .hit_bit (hit_bit)
    );

    // RAM ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {sel_reg, word_reg};
        mem_wdata = rd_data_reg;
        mem_raddr = {sel_reg, word_reg + WADDR_W'(1)};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_raddr = {map_select, (opcode == OP_FREE) ? free_word : WADDR_W'(0)};
            end
            ST_FREE:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
            end
            ST_SCAN:
            begin
                mem_we    = hit;
                mem_wdata = rd_data_reg | (WORD_BITS'(1) << hit_bit);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sel_next    = sel_reg;
        limit_next  = limit_reg;
        word_next   = word_reg;
        base_next   = base_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        number_next = '0;
        status_next = STATUS_OK;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    sel_next   = map_select;
                    limit_next = limit_in;
                    if (opcode == OP_FREE)
                    begin
                        if (free_bad)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            word_next  = free_word;
                            bit_next   = free_idx[BIT_W-1:0];
                            state_next = ST_FREE;
                        end
                    end
                    else if (limit_in == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        word_next  = '0;
                        base_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FREE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    done_next   = 1'b1;
                    number_next = found_num[NUM_W-1:0];
                    state_next  = ST_IDLE;
                end
                else if (base_step >= BASE_W'(limit_reg))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FULL;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                    base_next = base_step;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            sel_reg    <= MAP_INODE;
            limit_reg  <= '0;
            word_reg   <= '0;
            base_reg   <= '0;
            bit_reg    <= '0;
            done_reg   <= 1'b0;
            number_reg <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            sel_reg    <= sel_next;
            limit_reg  <= limit_next;
            word_reg   <= word_next;
            base_reg   <= base_next;
            bit_reg    <= bit_next;
            done_reg   <= done_next;
            number_reg <= number_next;
            status_reg <= status_next;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign allocated_number = number_reg;
    assign status           = status_reg;

endmodule

`default_nettype wire
